// File: hdl/delta_varint_locus_decoder_macros.svh
// Assertion macros shared by the checker of the delta varint locus decoder.
// Holds nothing but macro definitions; no other file is needed.
`ifndef DELTA_VARINT_LOCUS_DECODER_MACROS_SVH
`define DELTA_VARINT_LOCUS_DECODER_MACROS_SVH

`define DVL_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define DVL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`define DVL_ASSERT_RESET(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dvl_pkg.sv
// Types and constants of the delta varint locus decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dvl_pkg;

    localparam int BYTE_W     = 8;
    localparam int LOC_W      = 64;
    localparam int IDX_W      = 32;
    localparam int DELTA_W    = 62;
    localparam int LEFT_W     = 3;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 112;
    localparam int M_PAYLOAD_W = BYTE_W + LOC_W + IDX_W + 1;
    localparam int PAD_W      = M_TDATA_W - M_PAYLOAD_W;

    localparam logic [BYTE_W-1:0] SEPARATOR  = 8'hff;
    localparam logic [BYTE_W-1:0] NAME_END   = 8'h00;
    localparam logic [5:0]        LOW6       = 6'h3f;
    localparam logic [1:0]        TOP_LONG   = 2'b11;
    localparam logic [1:0]        TOP_SHORT  = 2'b10;
    localparam logic [LEFT_W-1:0] LONG_CONT  = 3'd7;
    localparam logic [LEFT_W-1:0] SHORT_CONT = 3'd1;

    typedef enum logic [1:0] {
        PH_NAME_HEAD = 2'd0,
        PH_NAME      = 2'd1,
        PH_CODE      = 2'd2,
        PH_CONT      = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_TRUNC  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              vector_start;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] name_char;
        logic [LOC_W-1:0]  location;
        logic [IDX_W-1:0]  record_index;
        logic              first_of_sequence;
    } result_t;

    typedef struct packed {
        logic take;
        logic fire;
    } flow_t;

endpackage

`default_nettype wire

// File: hdl/dvl_in_reg.sv
// Input register of the delta varint locus decoder: holds one byte transaction.
// Depends on dvl_pkg.
`default_nettype none

module dvl_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dvl_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output dvl_pkg::item_t     item
);
    import dvl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dvl_core.sv
// Decoder state machine: name pass-through, varint assembly and location sum.
// Depends on dvl_pkg.
`default_nettype none

module dvl_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dvl_pkg::flow_t flow,
    input  wire dvl_pkg::item_t item,
    output logic                has_result,
    output dvl_pkg::result_t    result
);
    import dvl_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [DELTA_W-1:0] acc_reg, acc_next;
    logic [LOC_W-1:0]   loc_reg, loc_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic               fresh_reg, fresh_next;

    phase_t             ph;
    logic [LEFT_W-1:0]  left_cur;
    logic [DELTA_W-1:0] acc_cur;
    logic [DELTA_W-1:0] acc_shift;
    logic [LOC_W-1:0]   loc_cur;
    logic [IDX_W-1:0]   count_cur;
    logic               fresh_cur;
    logic [BYTE_W-1:0]  b;
    logic               emit;
    logic [LOC_W-1:0]   delta;
    logic [LOC_W-1:0]   loc_sum;

    assign b         = item.stream_byte;
    assign ph        = item.vector_start ? PH_NAME_HEAD : phase_reg;
    assign left_cur  = item.vector_start ? '0 : left_reg;
    assign acc_cur   = item.vector_start ? '0 : acc_reg;
    assign loc_cur   = item.vector_start ? '0 : loc_reg;
    assign count_cur = item.vector_start ? '0 : count_reg;
    assign fresh_cur = item.vector_start ? 1'b0 : fresh_reg;
    assign acc_shift = {acc_cur[DELTA_W-BYTE_W-1:0], b};

    always_comb begin
        phase_next  = ph;
        left_next   = left_cur;
        acc_next    = acc_cur;
        loc_next    = loc_cur;
        count_next  = count_cur;
        fresh_next  = fresh_cur;
        has_result  = 1'b0;
        emit        = 1'b0;
        delta       = {{(LOC_W-BYTE_W){1'b0}}, b};
        result      = '0;
        result.kind = KIND_NAME;

        case (ph)
            PH_NAME_HEAD, PH_NAME: begin
                if (ph == PH_NAME_HEAD && b == SEPARATOR) begin
                    phase_next = PH_NAME;
                end else begin
                    has_result       = 1'b1;
                    result.kind      = KIND_NAME;
                    result.name_char = b;
                    if (b == NAME_END) begin
                        loc_next   = '0;
                        fresh_next = 1'b1;
                        phase_next = PH_CODE;
                    end else begin
                        phase_next = PH_NAME;
                    end
                end
            end
            PH_CODE: begin
                if (b == SEPARATOR && !fresh_cur) begin
                    phase_next = PH_NAME;
                end else if (b[7:6] == TOP_LONG) begin
                    acc_next   = {{(DELTA_W-6){1'b0}}, b[5:0] & LOW6};
                    left_next  = LONG_CONT;
                    phase_next = PH_CONT;
                end else if (b[7:6] == TOP_SHORT) begin
                    acc_next   = {{(DELTA_W-6){1'b0}}, b[5:0] & LOW6};
                    left_next  = SHORT_CONT;
                    phase_next = PH_CONT;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_CONT: begin
                acc_next  = acc_shift;
                left_next = left_cur - 3'd1;
                if (left_next == '0) begin
                    delta      = {{(LOC_W-DELTA_W){1'b0}}, acc_shift};
                    emit       = 1'b1;
                    acc_next   = '0;
                    phase_next = PH_CODE;
                end
            end
            default: begin
                phase_next = PH_NAME_HEAD;
            end
        endcase

        loc_sum = loc_cur + delta;

        if (emit) begin
            has_result               = 1'b1;
            loc_next                 = loc_sum;
            result.kind              = KIND_RECORD;
            result.location          = loc_sum;
            result.record_index      = count_cur;
            result.first_of_sequence = fresh_cur;
            count_next               = count_cur + 32'd1;
            fresh_next               = 1'b0;
        end

        if (item.last_byte) begin
            if (phase_next == PH_CONT && !has_result) begin
                has_result  = 1'b1;
                result      = '0;
                result.kind = KIND_TRUNC;
            end
            phase_next = PH_NAME_HEAD;
            left_next  = '0;
            acc_next   = '0;
            loc_next   = '0;
            count_next = '0;
            fresh_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NAME_HEAD;
            left_reg  <= '0;
            acc_reg   <= '0;
            loc_reg   <= '0;
            count_reg <= '0;
            fresh_reg <= 1'b0;
        end else if (flow.fire) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            loc_reg   <= loc_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dvl_out_reg.sv
// Result register of the delta varint locus decoder, feeding the master port.
// Depends on dvl_pkg.
`default_nettype none

module dvl_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dvl_pkg::flow_t   flow,
    input  wire logic             has_result,
    input  wire dvl_pkg::result_t result,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dvl_pkg::result_t      m_result
);
    import dvl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (flow.fire) begin
            valid_next = has_result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (flow.fire && has_result) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: hdl/delta_varint_locus_decoder.sv
// A byte transaction is held in the input register; its result, if it has one, is
// loaded into the result register, which offers it as the result transaction.
// Throughput: one byte per cycle; a 64-bit location adder sits between the
// input register and the result register, and a stalled result stalls input.
// Reset: synchronous, active low aresetn; clears the decoder state and both
// valid flags, so the next byte is taken as the head of a name.
`default_nettype none

module delta_varint_locus_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // stream_byte[7:0]
    input  wire logic [dvl_pkg::S_TDATA_W-1:0]  s_tdata,
    // vector_start[0]
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // name_char[7:0], location[71:8], record_index[103:72],
    // first_of_sequence[104], zero padding[111:105]
    output logic [dvl_pkg::M_TDATA_W-1:0]       m_tdata,
    // kind[1:0]
    output logic [dvl_pkg::KIND_W-1:0]          m_tuser
);
    import dvl_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    flow_t   flow;
    logic    has_result;
    result_t result;
    result_t m_result;

    assign s_item.stream_byte  = s_tdata[BYTE_W-1:0];
    assign s_item.vector_start = s_tuser;
    assign s_item.last_byte    = s_tlast;

    assign flow.take = !m_tvalid || m_tready;
    assign flow.fire = item_valid && flow.take;

    dvl_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (flow.take),
        .item_valid (item_valid),
        .item       (item)
    );

    dvl_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flow       (flow),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    dvl_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flow       (flow),
        .has_result (has_result),
        .result     (result),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    assign m_tuser = m_result.kind;
    assign m_tdata = {{PAD_W{1'b0}},
                      m_result.first_of_sequence,
                      m_result.record_index,
                      m_result.location,
                      m_result.name_char};

endmodule

`default_nettype wire

// File: hdl/dvl_checker.sv
// Port-level checker of the delta varint locus decoder, bound to the top level.
// Depends on dvl_pkg and delta_varint_locus_decoder_macros.svh.
`default_nettype none

`include "delta_varint_locus_decoder_macros.svh"

module dvl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dvl_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [dvl_pkg::KIND_W-1:0]    m_tuser
);
    import dvl_pkg::*;

    `DVL_ASSERT_RESET(a_reset_clears_out, aclk, !aresetn, !m_tvalid, "result valid after reset")

    `DVL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `DVL_ASSERT_IMPL(a_trunc_empty, aclk, aresetn, m_tvalid && m_tuser == KIND_TRUNC, m_tdata == '0, "truncated code carries payload")

    `DVL_ASSERT_IMPL(a_name_only_char, aclk, aresetn, m_tvalid && m_tuser == KIND_NAME, m_tdata[M_TDATA_W-1:BYTE_W] == '0, "name byte carries record fields")

    `DVL_ASSERT_IMPL(a_record_no_char, aclk, aresetn, m_tvalid && m_tuser == KIND_RECORD, m_tdata[BYTE_W-1:0] == '0, "record carries a name byte")

endmodule

bind delta_varint_locus_decoder dvl_checker u_dvl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
